FILE: rtl/v2aa_pkg.sv
// Shared types and constants for the vector to axis-angle rotation block.
package v2aa_pkg;

  localparam int COORD_W      = 16;
  localparam int AXIS_W       = 16;
  localparam int ANGLE_W      = 16;
  localparam int MAG_W        = 16;
  localparam int ACC_FRAC     = 16;
  localparam int ANGLE_FRAC   = 8;
  localparam int HALF_TURN    = 180;
  localparam int CORDIC_STEPS = 20;

  // Largest angle code: 180 degrees at the output scale
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = ANGLE_W'(HALF_TURN << ANGLE_FRAC);

  // atan(2^-i) in degrees, 16 fraction bits
  localparam logic [21:0] ATAN_TAB [CORDIC_STEPS] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379,
    22'd117304,  22'd58666,   22'd29335,  22'd14668,  22'd7334,
    22'd3667,    22'd1833,    22'd917,    22'd458,    22'd229,
    22'd115,     22'd57,      22'd29,     22'd14,     22'd7
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] vec_x;
    logic signed [COORD_W-1:0] vec_y;
    logic signed [COORD_W-1:0] vec_z;
  } vec_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic [ANGLE_W-1:0]       angle_deg;
    logic [MAG_W-1:0]         magnitude;
    logic                     degenerate;
  } rot_t;

endpackage

FILE: rtl/vector_to_axis_angle_top.sv
// Vector to axis-angle rotation: fully pipelined top level.
//
// Takes one vector per clock unless a stalled result holds the pipe, and returns
// the rotation that turns +z onto it: unit axis (-y, x)/p in Q2.14, angle
// atan2(p, z) in degrees with 8 fraction bits, and the rounded length. Three
// input stages take absolute values, squares and sums; then 51 steps run side
// by side: a 31-step restoring divider per axis component followed by a
// 16-step square root, a 31-step square root of the scaled planar energy
// followed by a 20-step CORDIC for the angle, and a 16-step square root for
// the length. A final stage rounds and registers the result. The whole pipe
// advances together and holds while a valid result is stalled at the output.
module vector_to_axis_angle_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           vec_valid,
  output logic           vec_stall,
  input  v2aa_pkg::vec_t vec,
  output logic           rot_valid,
  input  logic           rot_stall,
  output v2aa_pkg::rot_t rot
);
  import v2aa_pkg::*;

  localparam int DIV_STEPS = 31;
  localparam int MAG_STEPS = 16;
  localparam int ANG_STEPS = 31;
  localparam int AXS_START = DIV_STEPS;
  localparam int AXS_STEPS = 16;
  localparam int COR_START = ANG_STEPS;
  localparam int NSTEP     = COR_START + CORDIC_STEPS;

  localparam logic [23:0] FULL = 24'(HALF_TURN << ACC_FRAC);
  localparam logic [23:0] HALF = 24'(HALF_TURN << (ACC_FRAC - 1));
  localparam logic [23:0] RND  = 24'(1 << (ACC_FRAC - ANGLE_FRAC - 1));

  typedef struct packed {
    logic degen, xneg, ypos, zneg, zzero;
    logic [31:0] dvs;
    logic [31:0] dx_rem, dy_rem;
    logic [30:0] dx_lo, dy_lo, dx_q, dy_q;
    logic [31:0] mg_rad;
    logic [17:0] mg_rem;
    logic [15:0] mg_root;
    logic [61:0] an_rad;
    logic [32:0] an_rem;
    logic [30:0] an_root;
    logic [31:0] zm;
    logic [31:0] kx_rad, ky_rad;
    logic [17:0] kx_rem, ky_rem;
    logic [15:0] kx_root, ky_root;
    logic signed [35:0] cx, cy;
    logic signed [25:0] acc;
  } stage_t;

  // One bit of a 32-bit radicand square root: {rad, rem, root}
  function automatic logic [65:0] sqrt16_step(input logic [31:0] rad,
                                               input logic [17:0] rem,
                                               input logic [15:0] root);
    logic [19:0] a;
    logic [19:0] d;
    a = {rem, rad[31:30]};
    d = a - {2'b00, root, 2'b01};
    if (d[19]) begin
      return {rad[29:0], 2'b00, a[17:0], root[14:0], 1'b0};
    end
    return {rad[29:0], 2'b00, d[17:0], root[14:0], 1'b1};
  endfunction

  // One bit of a 62-bit radicand square root: {rad, rem, root}
  function automatic logic [125:0] sqrt31_step(input logic [61:0] rad,
                                                input logic [32:0] rem,
                                                input logic [30:0] root);
    logic [35:0] a;
    logic [35:0] d;
    a = {1'b0, rem, rad[61:60]};
    d = a - {3'b000, root, 2'b01};
    if (d[35]) begin
      return {rad[59:0], 2'b00, a[32:0], root[29:0], 1'b0};
    end
    return {rad[59:0], 2'b00, d[32:0], root[29:0], 1'b1};
  endfunction

  // One quotient bit of restoring division: {rem, lo, q}
  function automatic logic [93:0] div_step(input logic [31:0] rem,
                                            input logic [30:0] lo,
                                            input logic [30:0] q,
                                            input logic [31:0] dvs);
    logic [32:0] a;
    logic [33:0] d;
    a = {rem, lo[30]};
    d = {1'b0, a} - {2'b00, dvs};
    if (d[33]) begin
      return {a[31:0], lo[29:0], 1'b0, q[29:0], 1'b0};
    end
    return {d[31:0], lo[29:0], 1'b0, q[29:0], 1'b1};
  endfunction

  logic adv;
  logic p0_v, p1_v, p2_v;
  logic [15:0] p0_ax, p0_ay, p0_az, p1_az, p2_az;
  logic [3:0] p0_fl, p1_fl, p2_fl;  // xneg, ypos, zneg, zzero
  logic [31:0] p1_ax2, p1_ay2, p1_az2, p2_ax2, p2_ay2, p2_s, p2_t;
  stage_t seed;
  stage_t st [NSTEP];
  logic vld [NSTEP];
  rot_t rot_next;

  // Whole pipe moves unless a finished result is held
  assign adv       = !rot_valid || !rot_stall;
  assign vec_stall = !adv;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      p0_v <= 1'b0;
      p1_v <= 1'b0;
      p2_v <= 1'b0;
    end else if (adv) begin
      p0_v <= vec_valid;
      p1_v <= p0_v;
      p2_v <= p1_v;
    end
  end

  // Input stages: magnitudes, squares, sums
  always_ff @(posedge clk) begin
    if (adv) begin
      p0_ax  <= vec.vec_x[15] ? 16'(-vec.vec_x) : vec.vec_x;
      p0_ay  <= vec.vec_y[15] ? 16'(-vec.vec_y) : vec.vec_y;
      p0_az  <= vec.vec_z[15] ? 16'(-vec.vec_z) : vec.vec_z;
      p0_fl  <= {vec.vec_x[15], !vec.vec_y[15] && (vec.vec_y != '0),
                 vec.vec_z[15], vec.vec_z == '0};
      p1_ax2 <= 32'(p0_ax) * 32'(p0_ax);
      p1_ay2 <= 32'(p0_ay) * 32'(p0_ay);
      p1_az2 <= 32'(p0_az) * 32'(p0_az);
      p1_az  <= p0_az;
      p1_fl  <= p0_fl;
      p2_s   <= p1_ax2 + p1_ay2;
      p2_t   <= p1_ax2 + p1_ay2 + p1_az2;
      p2_ax2 <= p1_ax2;
      p2_ay2 <= p1_ay2;
      p2_az  <= p1_az;
      p2_fl  <= p1_fl;
    end
  end

  // Starting values of the dividers and the length and angle square roots
  always_comb begin
    seed        = '0;
    seed.degen  = (p2_s == '0);
    {seed.xneg, seed.ypos, seed.zneg, seed.zzero} = p2_fl;
    seed.dvs    = p2_s;
    seed.dx_rem = p2_ay2 >> 1;
    seed.dx_lo  = {p2_ay2[0], 30'b0};
    seed.dy_rem = p2_ax2 >> 1;
    seed.dy_lo  = {p2_ax2[0], 30'b0};
    seed.mg_rad = p2_t;
    if (p2_s[31:30] == 2'b00) begin
      seed.an_rad = {p2_s[29:0], 32'b0};
      seed.zm     = {p2_az, 16'b0};
    end else begin
      seed.an_rad = {p2_s, 30'b0};
      seed.zm     = {1'b0, p2_az, 15'b0};
    end
  end

  // Step pipeline
  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    localparam int CI = (j >= COR_START) ? j - COR_START : 0;
    stage_t src, nxt;
    logic signed [35:0] x0, y0;
    logic signed [25:0] a0;

    if (j == 0) begin : g_first
      assign src = seed;
    end else begin : g_rest
      assign src = st[j-1];
    end

    always_comb begin
      nxt = src;
      x0  = src.cx;
      y0  = src.cy;
      a0  = src.acc;
      if (j < DIV_STEPS) begin
        {nxt.dx_rem, nxt.dx_lo, nxt.dx_q} =
          div_step(src.dx_rem, src.dx_lo, src.dx_q, src.dvs);
        {nxt.dy_rem, nxt.dy_lo, nxt.dy_q} =
          div_step(src.dy_rem, src.dy_lo, src.dy_q, src.dvs);
      end
      if (j < MAG_STEPS) begin
        {nxt.mg_rad, nxt.mg_rem, nxt.mg_root} =
          sqrt16_step(src.mg_rad, src.mg_rem, src.mg_root);
      end
      if (j < ANG_STEPS) begin
        {nxt.an_rad, nxt.an_rem, nxt.an_root} =
          sqrt31_step(src.an_rad, src.an_rem, src.an_root);
      end
      // axis root of the quotient
      if (j == AXS_START) begin
        {nxt.kx_rad, nxt.kx_rem, nxt.kx_root} =
          sqrt16_step({1'b0, src.dx_q}, 18'd0, 16'd0);
        {nxt.ky_rad, nxt.ky_rem, nxt.ky_root} =
          sqrt16_step({1'b0, src.dy_q}, 18'd0, 16'd0);
      end else if (j > AXS_START && j < AXS_START + AXS_STEPS) begin
        {nxt.kx_rad, nxt.kx_rem, nxt.kx_root} =
          sqrt16_step(src.kx_rad, src.kx_rem, src.kx_root);
        {nxt.ky_rad, nxt.ky_rem, nxt.ky_root} =
          sqrt16_step(src.ky_rad, src.ky_rem, src.ky_root);
      end
      // CORDIC vectoring, quarter turn first for negative z
      if (j >= COR_START) begin
        if (j == COR_START) begin
          if (src.zneg) begin
            x0 = $signed({5'b0, src.an_root});
            y0 = $signed({4'b0, src.zm});
            a0 = $signed({2'b0, HALF});
          end else begin
            x0 = $signed({4'b0, src.zm});
            y0 = $signed({5'b0, src.an_root});
            a0 = '0;
          end
        end
        if (!y0[35]) begin
          nxt.cx  = x0 + (y0 >>> CI);
          nxt.cy  = y0 - (x0 >>> CI);
          nxt.acc = a0 + $signed({4'b0, ATAN_TAB[CI]});
        end else begin
          nxt.cx  = x0 - (y0 >>> CI);
          nxt.cy  = y0 + (x0 >>> CI);
          nxt.acc = a0 - $signed({4'b0, ATAN_TAB[CI]});
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[j] <= nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (adv) begin
        vld[j] <= (j == 0) ? p2_v : vld[(j == 0) ? 0 : j - 1];
      end
    end
  end

  // Final rounding and special cases
  always_comb begin
    stage_t      f;
    logic [16:0] kxm, kym;
    logic [23:0] accc, asum;
    f = st[NSTEP-1];
    rot_next.magnitude = f.mg_root + 16'({2'b00, f.mg_root} < f.mg_rem);
    kxm = ({1'b0, f.kx_root} + 17'd1) >> 1;
    kym = ({1'b0, f.ky_root} + 17'd1) >> 1;
    if (f.degen) begin
      rot_next.axis_x = '0;
      rot_next.axis_y = '0;
    end else begin
      rot_next.axis_x = f.ypos ? 16'(-kxm) : kxm[15:0];
      rot_next.axis_y = f.xneg ? 16'(-kym) : kym[15:0];
    end
    if (f.degen) begin
      accc = f.zneg ? FULL : '0;
    end else if (f.zzero) begin
      accc = HALF;
    end else if (f.acc < 0) begin
      accc = '0;
    end else if (f.acc > $signed({2'b0, FULL})) begin
      accc = FULL;
    end else begin
      accc = f.acc[23:0];
    end
    asum = accc + RND;
    rot_next.angle_deg  = 16'(asum >> (ACC_FRAC - ANGLE_FRAC));
    rot_next.degenerate = f.degen;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_valid <= 1'b0;
    end else if (adv) begin
      rot_valid <= vld[NSTEP-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rot <= rot_next;
    end
  end

endmodule

FILE: rtl/v2aa_checker.sv
// Port-level checks for the vector to axis-angle block, bound to the top level.
module v2aa_checker (
  input logic           clk,
  input logic           rst,
  input logic           vec_stall,
  input logic           rot_valid,
  input logic           rot_stall,
  input v2aa_pkg::rot_t rot
);
  import v2aa_pkg::*;

  // Output empties on reset
  a_reset_clear: assert property (@(posedge clk) rst |=> !rot_valid)
    else $error("result valid after reset");

  // Held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rot_valid && rot_stall |=> rot_valid && $stable(rot))
    else $error("stalled result changed");

  // Input backs up exactly when a finished result is held
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    vec_stall == (rot_valid && rot_stall))
    else $error("input stall does not follow output hold");

  // No axis for a vector on the z line
  a_degen_axis: assert property (@(posedge clk) disable iff (rst)
    rot_valid && rot.degenerate |-> rot.axis_x == '0 && rot.axis_y == '0)
    else $error("degenerate result with nonzero axis");

  // Angle stays within a half turn
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    rot_valid |-> rot.angle_deg <= ANGLE_MAX)
    else $error("angle above 180 degrees");

endmodule

bind vector_to_axis_angle_top v2aa_checker u_v2aa_checker (.*);

FILE: test/vector_to_axis_angle_top_tb.sv
// Self-checking testbench for the vector to axis-angle rotation block.
module vector_to_axis_angle_top_tb;
  import v2aa_pkg::*;

  localparam int NUM_RANDOM = 1150;
  localparam int QUIET_TAIL = 150;
  localparam int DRAIN_CYCLES = 80;
  localparam longint CYCLE_LIMIT = 200000;

  // atan(2^-i) in degrees, 16 fraction bits
  localparam longint ATAN_DEG [CORDIC_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };

  logic clk;
  logic rst;
  logic vec_valid;
  logic vec_stall;
  vec_t vec;
  logic rot_valid;
  logic rot_stall;
  rot_t rot;

  vec_t pending_vecs[$];
  rot_t expected_rots[$];
  int err_count;
  int sent_count;
  int recv_count;
  int degen_count;
  longint cycle_count;
  bit stim_done;
  bit quiet;
  int in_idle;
  int out_idle;

  vector_to_axis_angle_top u_dut (
    .clk(clk), .rst(rst),
    .vec_valid(vec_valid), .vec_stall(vec_stall), .vec(vec),
    .rot_valid(rot_valid), .rot_stall(rot_stall), .rot(rot)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Integer square root, floor
  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // round(m * 2^14 / sqrt(s)) with ties up, by search on exact squares
  function automatic longint unsigned unit_component(longint unsigned m,
                                                     longint unsigned s);
    logic [127:0] rhs;
    logic [127:0] lhs;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned t;
    rhs = 128'(m * m) << 30;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * mid - 1;
      lhs = 128'(t * t) * 128'(s);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  // atan2(sqrt(s), z) in degrees with 16 fraction bits
  function automatic longint polar_angle(longint z, longint unsigned s);
    longint cx;
    longint cy;
    longint acc;
    longint full;
    longint dx;
    longint dy;
    int sh;
    full = longint'(HALF_TURN) << ACC_FRAC;
    if (s == 0) return (z < 0) ? full : 0;
    if (z == 0) return full / 2;
    sh = 16;
    while (sh > 0 && (s >> (62 - 2 * sh)) != 0) sh--;
    acc = 0;
    if (z < 0) begin
      cx = longint'(floor_sqrt(s << (2 * sh)));
      cy = (-z) <<< sh;
      acc = full / 2;
    end else begin
      cx = z <<< sh;
      cy = longint'(floor_sqrt(s << (2 * sh)));
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = floor_shift(cy, i);
      dy = floor_shift(cx, i);
      if (cy >= 0) begin
        cx += dx; cy -= dy; acc += ATAN_DEG[i];
      end else begin
        cx -= dx; cy += dy; acc -= ATAN_DEG[i];
      end
    end
    if (acc < 0) acc = 0;
    if (acc > full) acc = full;
    return acc;
  endfunction

  // Expected rotation for one vector
  function automatic rot_t predict_rotation(vec_t v);
    rot_t r;
    longint x;
    longint y;
    longint z;
    longint unsigned s;
    longint unsigned t;
    longint unsigned len;
    longint unsigned kx;
    longint unsigned ky;
    longint unsigned ang;
    x = longint'(v.vec_x);
    y = longint'(v.vec_y);
    z = longint'(v.vec_z);
    s = longint'(x * x + y * y);
    t = s + longint'(z * z);
    len = floor_sqrt(t);
    if (t - len * len > len) len++;
    if (len > 65535) len = 65535;
    kx = 0;
    ky = 0;
    if (s != 0) begin
      kx = unit_component(longint'(y < 0 ? -y : y), s);
      ky = unit_component(longint'(x < 0 ? -x : x), s);
      if (y > 0) kx = -kx;
      if (x < 0) ky = -ky;
    end
    ang = longint'(polar_angle(z, s));
    ang = (ang + (64'd1 << (ACC_FRAC - ANGLE_FRAC - 1))) >> (ACC_FRAC - ANGLE_FRAC);
    r.axis_x = kx[15:0];
    r.axis_y = ky[15:0];
    r.angle_deg = ang[15:0];
    r.magnitude = len[15:0];
    r.degenerate = (s == 0);
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch at result %0d: %s got %0d expected %0d",
             recv_count, field, got, want);
    err_count++;
  endtask

  task automatic push_vec(int x, int y, int z);
    vec_t v;
    v.vec_x = x[15:0];
    v.vec_y = y[15:0];
    v.vec_z = z[15:0];
    pending_vecs.push_back(v);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1: return int'($urandom_range(0, 6)) - 3;
      2: return int'($urandom_range(0, 512)) - 256;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // Stimulus: directed corners, then random vectors
  initial begin
    int x;
    int y;
    int z;
    rst = 1'b1;
    err_count = 0;
    stim_done = 1'b0;
    push_vec(0, 0, 0);
    push_vec(0, 0, 100);
    push_vec(0, 0, -100);
    push_vec(0, 0, 32767);
    push_vec(0, 0, -32768);
    push_vec(5, 0, 0);
    push_vec(0, -7, 0);
    push_vec(32767, 32767, 32767);
    push_vec(-32768, -32768, -32768);
    push_vec(-32768, 32767, 0);
    push_vec(32767, -32768, -1);
    push_vec(1, 1, 1);
    push_vec(-1, -1, -1);
    push_vec(1, 0, -32768);
    push_vec(0, 1, 32767);
    push_vec(3, 4, 0);
    push_vec(-3, 4, 12);
    push_vec(3, -4, -12);
    push_vec(1, 0, 1);
    push_vec(-32768, 0, 0);
    push_vec(0, -32768, 1);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      x = rand_coord();
      y = rand_coord();
      z = rand_coord();
      if ($urandom_range(0, 15) == 0) begin
        x = 0; y = 0;
      end
      if ($urandom_range(0, 19) == 0) z = 0;
      push_vec(x, y, z);
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    stim_done = 1'b1;
  end

  // Driver and input idling
  always @(posedge clk) begin
    if (rst) begin
      vec_valid <= 1'b0;
      vec <= '0;
      in_idle <= 0;
      sent_count <= 0;
    end else begin
      automatic bit advance = !vec_valid || !vec_stall;
      if (vec_valid && !vec_stall) sent_count <= sent_count + 1;
      if (advance) begin
        if (in_idle > 0) begin
          in_idle <= in_idle - 1;
          vec_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          in_idle <= $urandom_range(1, 11) - 1;
          vec_valid <= 1'b0;
        end else if (pending_vecs.size() > 0) begin
          automatic vec_t v = pending_vecs.pop_front();
          vec <= v;
          vec_valid <= 1'b1;
          expected_rots.push_back(predict_rotation(v));
        end else begin
          vec_valid <= 1'b0;
        end
      end
    end
  end

  // Output stall bursts
  always @(posedge clk) begin
    if (rst) begin
      rot_stall <= 1'b0;
      out_idle <= 0;
    end else if (out_idle > 0) begin
      out_idle <= out_idle - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      rot_stall <= 1'b1;
      out_idle <= $urandom_range(1, 11) - 1;
    end else begin
      rot_stall <= 1'b0;
    end
  end

  initial begin
    vec_valid = 1'b0;
    vec = '0;
    rot_stall = 1'b0;
    in_idle = 0;
    out_idle = 0;
  end

  always_comb quiet = (pending_vecs.size() < QUIET_TAIL) && stim_done;

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      recv_count <= 0;
      degen_count <= 0;
    end else if (rot_valid && !rot_stall) begin
      if (expected_rots.size() == 0) begin
        $display("unexpected result transfer at cycle %0d", cycle_count);
        err_count++;
      end else begin
        automatic rot_t want = expected_rots.pop_front();
        if (rot.axis_x !== want.axis_x)
          report_mismatch("axis_x", rot.axis_x, want.axis_x);
        if (rot.axis_y !== want.axis_y)
          report_mismatch("axis_y", rot.axis_y, want.axis_y);
        if (rot.angle_deg !== want.angle_deg)
          report_mismatch("angle_deg", rot.angle_deg, want.angle_deg);
        if (rot.magnitude !== want.magnitude)
          report_mismatch("magnitude", rot.magnitude, want.magnitude);
        if (rot.degenerate !== want.degenerate)
          report_mismatch("degenerate", rot.degenerate, want.degenerate);
        if (want.degenerate) degen_count <= degen_count + 1;
      end
      recv_count <= recv_count + 1;
    end
  end

  // End of run and timeout
  always @(posedge clk) begin
    if (rst) begin
      cycle_count <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("vector_to_axis_angle_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    wait (pending_vecs.size() == 0 && expected_rots.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d rotations from %0d vectors (%0d with no planar part)",
             recv_count, sent_count, degen_count);
    $display("covered axis corners, zero and negative z, and random stalls on both sides");
    if (err_count == 0) begin
      $display("vector_to_axis_angle_top regression: pass");
    end else begin
      $display("vector_to_axis_angle_top regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/v2aa_pkg.sv
rtl/vector_to_axis_angle_top.sv
rtl/v2aa_checker.sv
test/vector_to_axis_angle_top_tb.sv
